@@ src/omkc_pkg.sv @@
`default_nettype none
package omkc_pkg;

	localparam int MAX_SETTINGS = 32;
	localparam int STEP_COUNT   = 100;
	localparam int COARSE_STEP  = 10;

	localparam int ROW_W   = $clog2(MAX_SETTINGS);
	localparam int CNT_W   = ROW_W + 1;
	localparam int LEVEL_W = $clog2(STEP_COUNT + 1);
	localparam int CMD_W   = 4;
	localparam int CFG_W   = 6;
	localparam int REG_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_OTHER  = 4'd0,
		CMD_TOGGLE = 4'd1,
		CMD_ESC    = 4'd2,
		CMD_UP     = 4'd3,
		CMD_DOWN   = 4'd4,
		CMD_LEFT   = 4'd5,
		CMD_RIGHT  = 4'd6,
		CMD_TAB    = 4'd7,
		CMD_PGUP   = 4'd8,
		CMD_PGDN   = 4'd9,
		CMD_HOME   = 4'd10,
		CMD_END    = 4'd11,
		CMD_WRITE  = 4'd12
	} cmd_t;

	typedef enum logic [REG_W-1:0] {
		REG_SETTING_COUNT  = 2'd0,
		REG_GEOMETRY_START = 2'd1,
		REG_TUBE_START     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PAGE_LOW  = 2'd0,
		PAGE_MID  = 2'd1,
		PAGE_HIGH = 2'd2
	} page_t;

	typedef struct packed {
		logic [CNT_W-1:0] count_eff;
		logic [CFG_W-1:0] geometry_start;
		logic [CFG_W-1:0] tube_start;
	} menu_cfg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               shift_held;
		logic [ROW_W-1:0]   write_index;
		logic [LEVEL_W-1:0] write_level;
	} item_t;

	typedef struct packed {
		logic               handled;
		logic               menu_visible;
		logic [ROW_W-1:0]   selected_row;
		page_t              selected_page;
		logic [LEVEL_W-1:0] selected_level;
	} result_t;

	typedef struct packed {
		logic               en;
		logic [ROW_W-1:0]   addr;
		logic [LEVEL_W-1:0] data;
	} level_wr_t;

endpackage
`default_nettype wire

@@ src/omkc_ifs.sv @@
`default_nettype none
interface omkc_item_if;
	import omkc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic                 shift_held;
	logic [ROW_W-1:0]     write_index;
	logic [LEVEL_W-1:0]   write_level;
	modport source (output valid, cmd, shift_held, write_index, write_level, input ready);
	modport sink (input valid, cmd, shift_held, write_index, write_level, output ready);
endinterface

interface omkc_result_if;
	import omkc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 handled;
	logic                 menu_visible;
	logic [ROW_W-1:0]     selected_row;
	logic [1:0]           selected_page;
	logic [LEVEL_W-1:0]   selected_level;
	modport source (output valid, handled, menu_visible, selected_row, selected_page,
		selected_level, input ready);
	modport sink (input valid, handled, menu_visible, selected_row, selected_page,
		selected_level, output ready);
endinterface

interface omkc_cfg_if;
	import omkc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_W-1:0]     index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/omkc_cfg.sv @@
`default_nettype none
module omkc_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	omkc_cfg_if.sink         cfg,
	output omkc_pkg::menu_cfg_t menu_cfg
);
	import omkc_pkg::*;

	logic [CFG_W-1:0] setting_count_q;
	logic [CFG_W-1:0] geometry_start_q;
	logic [CFG_W-1:0] tube_start_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_count_q  <= CFG_W'(18);
			geometry_start_q <= CFG_W'(6);
			tube_start_q     <= CFG_W'(12);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SETTING_COUNT:  setting_count_q  <= cfg.data;
				REG_GEOMETRY_START: geometry_start_q <= cfg.data;
				REG_TUBE_START:     tube_start_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// A count of zero behaves as one row; anything past the store depth is clamped.
	always_comb begin
		if (setting_count_q == '0) begin
			menu_cfg.count_eff = CNT_W'(1);
		end else if (CNT_W'(setting_count_q) > CNT_W'(MAX_SETTINGS)) begin
			menu_cfg.count_eff = CNT_W'(MAX_SETTINGS);
		end else begin
			menu_cfg.count_eff = CNT_W'(setting_count_q);
		end
		menu_cfg.geometry_start = geometry_start_q;
		menu_cfg.tube_start     = tube_start_q;
	end

endmodule
`default_nettype wire

@@ src/omkc_levels.sv @@
`default_nettype none
module omkc_levels (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire omkc_pkg::level_wr_t            wr,
	input  wire logic [omkc_pkg::ROW_W-1:0]     rd_addr,
	output logic [omkc_pkg::LEVEL_W-1:0]        rd_data
);
	import omkc_pkg::*;

	logic [LEVEL_W-1:0] level_q [MAX_SETTINGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SETTINGS; i++) begin
				level_q[i] <= '0;
			end
		end else if (wr.en) begin
			level_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = level_q[rd_addr];

endmodule
`default_nettype wire

@@ src/omkc_step.sv @@
`default_nettype none
module omkc_step (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire omkc_pkg::menu_cfg_t         menu_cfg,
	input  wire omkc_pkg::item_t             item_in,
	input  wire logic                        fire,
	input  wire logic [omkc_pkg::LEVEL_W-1:0] rd_data,
	output logic [omkc_pkg::ROW_W-1:0]       rd_addr,
	output omkc_pkg::level_wr_t              wr,
	output omkc_pkg::result_t                result,
	output logic                             step_ok
);
	import omkc_pkg::*;

	logic             shown_q;
	logic [ROW_W-1:0] row_q;
	logic             shown_d;
	logic [ROW_W-1:0] row_d;
	logic             row_set;
	logic             handled;
	logic             wr_en;
	logic [ROW_W-1:0] wr_addr;
	logic [LEVEL_W-1:0] wr_data;
	page_t            page_cur;
	page_t            page_next;
	page_t            page_prev;
	logic [CNT_W-1:0] count_q;
	logic [ROW_W-1:0] wrap_q;
	logic [CNT_W-1:0] wrap_inc;
	logic [LEVEL_W:0] step_size;
	logic [LEVEL_W:0] level_ext;
	logic [LEVEL_W:0] level_inc;
	logic [LEVEL_W-1:0] level_up;
	logic [LEVEL_W-1:0] level_down;
	logic [LEVEL_W-1:0] write_sat;

	function automatic page_t page_of(input logic [ROW_W-1:0] row, input menu_cfg_t c);
		page_t p;
		if (CFG_W'(row) < c.geometry_start) begin
			p = PAGE_LOW;
		end else if (CFG_W'(row) < c.tube_start) begin
			p = PAGE_MID;
		end else begin
			p = PAGE_HIGH;
		end
		return p;
	endfunction

	// Pages are contiguous, so the first row of a page follows from its start bounds.
	// A page with no rows below the count falls back to row zero.
	function automatic logic [ROW_W-1:0] first_of(input page_t p, input menu_cfg_t c);
		logic [CFG_W-1:0] tube_first;
		logic [ROW_W-1:0] r;
		tube_first = (c.geometry_start > c.tube_start) ? c.geometry_start : c.tube_start;
		r = '0;
		case (p)
			PAGE_MID: begin
				if (c.geometry_start < c.tube_start && c.geometry_start < c.count_eff) begin
					r = c.geometry_start[ROW_W-1:0];
				end
			end
			PAGE_HIGH: begin
				if (tube_first < c.count_eff) begin
					r = tube_first[ROW_W-1:0];
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	assign page_cur  = page_of(row_q, menu_cfg);
	assign page_next = (page_cur == PAGE_HIGH) ? PAGE_LOW :
		(page_cur == PAGE_LOW) ? PAGE_MID : PAGE_HIGH;
	assign page_prev = (page_cur == PAGE_LOW) ? PAGE_HIGH :
		(page_cur == PAGE_HIGH) ? PAGE_MID : PAGE_LOW;

	// wrap_q holds the current row reduced modulo the count, so up and down only
	// ever step by one inside the range. A new count restarts the reduction from
	// the row, one subtraction per cycle, and items wait until it is done.
	assign step_ok  = (count_q == menu_cfg.count_eff) && (CNT_W'(wrap_q) < count_q);
	assign wrap_inc = CNT_W'(wrap_q) + CNT_W'(1);

	// Level steps act on the current row, which is also the row read from the store.
	assign step_size  = item_in.shift_held ? (LEVEL_W+1)'(COARSE_STEP) : (LEVEL_W+1)'(1);
	assign level_ext  = {1'b0, rd_data};
	assign level_inc  = level_ext + step_size;
	assign level_up   = (level_inc > (LEVEL_W+1)'(STEP_COUNT)) ? LEVEL_W'(STEP_COUNT) :
		level_inc[LEVEL_W-1:0];
	assign level_down = (level_ext < step_size) ? '0 : LEVEL_W'(level_ext - step_size);
	assign write_sat  = (item_in.write_level > LEVEL_W'(STEP_COUNT)) ? LEVEL_W'(STEP_COUNT) :
		item_in.write_level;

	always_comb begin
		shown_d = shown_q;
		row_d   = row_q;
		row_set = 1'b0;
		handled = 1'b0;
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = '0;
		case (item_in.cmd)
			CMD_TOGGLE: begin
				handled = 1'b1;
				shown_d = !shown_q;
				if (!shown_q) begin
					row_d   = '0;
					row_set = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (CNT_W'(item_in.write_index) < menu_cfg.count_eff) begin
					handled = 1'b1;
					wr_en   = 1'b1;
					wr_addr = item_in.write_index;
					wr_data = write_sat;
				end
			end
			CMD_ESC: begin
				if (shown_q) begin
					handled = 1'b1;
					shown_d = 1'b0;
				end
			end
			CMD_UP: begin
				if (shown_q) begin
					handled = 1'b1;
					row_set = 1'b1;
					row_d   = (wrap_q == '0) ?
						ROW_W'(menu_cfg.count_eff - CNT_W'(1)) : wrap_q - ROW_W'(1);
				end
			end
			CMD_DOWN: begin
				if (shown_q) begin
					handled = 1'b1;
					row_set = 1'b1;
					row_d   = (wrap_inc == menu_cfg.count_eff) ? '0 : wrap_inc[ROW_W-1:0];
				end
			end
			CMD_LEFT: begin
				if (shown_q) begin
					handled = 1'b1;
					wr_en   = 1'b1;
					wr_data = level_down;
				end
			end
			CMD_RIGHT: begin
				if (shown_q) begin
					handled = 1'b1;
					wr_en   = 1'b1;
					wr_data = level_up;
				end
			end
			CMD_TAB: begin
				if (shown_q) begin
					handled = 1'b1;
					row_set = 1'b1;
					row_d   = first_of(item_in.shift_held ? page_prev : page_next, menu_cfg);
				end
			end
			CMD_PGUP: begin
				if (shown_q) begin
					handled = 1'b1;
					row_set = 1'b1;
					row_d   = first_of(page_prev, menu_cfg);
				end
			end
			CMD_PGDN: begin
				if (shown_q) begin
					handled = 1'b1;
					row_set = 1'b1;
					row_d   = first_of(page_next, menu_cfg);
				end
			end
			CMD_HOME: begin
				if (shown_q) begin
					handled = 1'b1;
					wr_en   = 1'b1;
					wr_data = '0;
				end
			end
			CMD_END: begin
				if (shown_q) begin
					handled = 1'b1;
					wr_en   = 1'b1;
					wr_data = LEVEL_W'(STEP_COUNT);
				end
			end
			default: ;
		endcase
	end

	assign rd_addr = row_d;

	assign wr.en   = wr_en && fire;
	assign wr.addr = wr_addr;
	assign wr.data = wr_data;

	// The reported level includes a store write made by this same item.
	always_comb begin
		result.handled       = handled;
		result.menu_visible  = shown_d;
		result.selected_row  = row_d;
		result.selected_page = page_of(row_d, menu_cfg);
		result.selected_level = (wr_en && wr_addr == row_d) ? wr_data : rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= 1'b0;
			row_q   <= '0;
		end else if (fire) begin
			shown_q <= shown_d;
			row_q   <= row_d;
		end
	end

	// Every row that an item selects is already inside the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wrap_q  <= '0;
		end else if (count_q != menu_cfg.count_eff) begin
			count_q <= menu_cfg.count_eff;
			wrap_q  <= row_q;
		end else if (CNT_W'(wrap_q) >= count_q) begin
			wrap_q <= wrap_q - count_q[ROW_W-1:0];
		end else if (fire && row_set) begin
			wrap_q <= row_d;
		end
	end

endmodule
`default_nettype wire

@@ src/osd_menu_key_controller_top.sv @@
`default_nettype none
// On-screen menu key controller. Each item on the item channel is one key or control
// event, and each produces exactly one result with the handled flag, the shown flag,
// the selected row, its page and the level of that row after the event. The block
// takes one item every clock cycle while the result sink keeps up and no row reduction
// is running. Each item passes through the input register, then the whole event is
// evaluated in a single combinational pass into the result register, from which it is
// offered. When the result sink stalls, one more item is still taken into the input
// register before the item channel drops ready. Configuration writes are taken at
// any time, one per cycle, but should only be issued while no items are in flight.
// A write that changes the setting count holds the next item while the selected row
// is reduced modulo the new count, one subtraction per cycle. The level store comes
// out of reset cleared to zero, with no setup time.
module osd_menu_key_controller_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	omkc_item_if.sink  item,
	omkc_result_if.source result,
	omkc_cfg_if.sink   cfg
);
	import omkc_pkg::*;

	menu_cfg_t          menu_cfg;
	item_t              item_s1;
	logic               valid_s1;
	result_t            result_s2;
	logic               valid_s2;
	result_t            result_comb;
	level_wr_t          level_wr;
	logic [ROW_W-1:0]   rd_addr;
	logic [LEVEL_W-1:0] rd_data;
	logic               step_ok;
	logic               advance;
	logic               accept;

	assign advance    = valid_s1 && step_ok && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd         <= cmd_t'(item.cmd);
			item_s1.shift_held  <= item.shift_held;
			item_s1.write_index <= item.write_index;
			item_s1.write_level <= item.write_level;
		end
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	omkc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.menu_cfg (menu_cfg)
	);

	omkc_levels u_levels (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (level_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	omkc_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.menu_cfg (menu_cfg),
		.item_in  (item_s1),
		.fire     (advance),
		.rd_data  (rd_data),
		.rd_addr  (rd_addr),
		.wr       (level_wr),
		.result   (result_comb),
		.step_ok  (step_ok)
	);

	assign result.valid          = valid_s2;
	assign result.handled        = result_s2.handled;
	assign result.menu_visible   = result_s2.menu_visible;
	assign result.selected_row   = result_s2.selected_row;
	assign result.selected_page  = result_s2.selected_page;
	assign result.selected_level = result_s2.selected_level;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import omkc_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int PHASE_ITEMS  = 160;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PAGE_COUNT   = 3;

	// Codes outside the named event set; the block must ignore them.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd13;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;
	// Register index with no register behind it.
	localparam logic [REG_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic               shift;
		logic [ROW_W-1:0]   index;
		logic [LEVEL_W-1:0] level;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               item_valid = 1'b0;
	logic [CMD_W-1:0]   item_cmd = '0;
	logic               item_shift = 1'b0;
	logic [ROW_W-1:0]   item_index = '0;
	logic [LEVEL_W-1:0] item_level = '0;
	logic               result_ready = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [REG_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	omkc_item_if   item_ch ();
	omkc_result_if result_ch ();
	omkc_cfg_if    cfg_ch ();

	assign item_ch.valid       = item_valid;
	assign item_ch.cmd         = item_cmd;
	assign item_ch.shift_held  = item_shift;
	assign item_ch.write_index = item_index;
	assign item_ch.write_level = item_level;
	assign result_ch.ready     = result_ready;
	assign cfg_ch.valid        = cfg_valid;
	assign cfg_ch.index        = cfg_index;
	assign cfg_ch.data         = cfg_data;

	osd_menu_key_controller_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	key_event_t  pending_events[$];
	result_t     expected_results[$];
	bit          item_fire = 1'b0;
	bit          result_fire = 1'b0;
	bit          quiet = 1'b0;
	bit          gen_shown = 1'b0;
	int          send_wait = 0;
	int          hold_off = 0;
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	key_event_t  next_event;
	result_t     want;

	// Shadow copy of the menu state and its registers.
	int cfg_count = 18;
	int cfg_geo   = 6;
	int cfg_tube  = 12;
	bit menu_shown = 1'b0;
	int cur_row = 0;
	int level_mem [MAX_SETTINGS];

	function automatic int page_of_row(int row);
		if (row < cfg_geo)
			return 0;
		if (row < cfg_tube)
			return 1;
		return 2;
	endfunction

	function automatic int page_head(int page, int n);
		for (int i = 0; i < n; i++)
			if (page_of_row(i) == page)
				return i;
		return 0;
	endfunction

	function automatic result_t predict_menu_result(key_event_t ev);
		int      n;
		int      pg;
		int      delta;
		result_t res;
		n = (cfg_count == 0) ? 1 : (cfg_count > MAX_SETTINGS) ? MAX_SETTINGS : cfg_count;
		delta = ev.shift ? COARSE_STEP : 1;
		res.handled = 1'b0;
		if (ev.cmd == CMD_TOGGLE) begin
			menu_shown = !menu_shown;
			if (menu_shown)
				cur_row = 0;
			res.handled = 1'b1;
		end else if (ev.cmd == CMD_WRITE) begin
			if (int'(ev.index) < n) begin
				level_mem[ev.index] = (int'(ev.level) > STEP_COUNT) ? STEP_COUNT
					: int'(ev.level);
				res.handled = 1'b1;
			end
		end else if (ev.cmd >= CMD_ESC && ev.cmd <= CMD_END && menu_shown) begin
			pg = page_of_row(cur_row);
			res.handled = 1'b1;
			case (ev.cmd)
				CMD_ESC: menu_shown = 1'b0;
				CMD_UP: cur_row = (cur_row + n - 1) % n;
				CMD_DOWN: cur_row = (cur_row + 1) % n;
				CMD_LEFT: begin
					level_mem[cur_row] = (level_mem[cur_row] < delta) ? 0
						: level_mem[cur_row] - delta;
				end
				CMD_RIGHT: begin
					level_mem[cur_row] = (level_mem[cur_row] + delta > STEP_COUNT) ? STEP_COUNT
						: level_mem[cur_row] + delta;
				end
				CMD_TAB: begin
					cur_row = page_head((pg + (ev.shift ? PAGE_COUNT - 1 : 1)) % PAGE_COUNT, n);
				end
				CMD_PGUP: cur_row = page_head((pg + PAGE_COUNT - 1) % PAGE_COUNT, n);
				CMD_PGDN: cur_row = page_head((pg + 1) % PAGE_COUNT, n);
				CMD_HOME: level_mem[cur_row] = 0;
				CMD_END: level_mem[cur_row] = STEP_COUNT;
				default: ;
			endcase
		end
		res.menu_visible   = menu_shown;
		res.selected_row   = cur_row[ROW_W-1:0];
		res.selected_page  = page_t'(page_of_row(cur_row));
		res.selected_level = level_mem[cur_row][LEVEL_W-1:0];
		return res;
	endfunction

	task automatic compare_field(string name, logic [7:0] expected, logic [7:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		item_fire   = arst_n && item_ch.valid && item_ch.ready;
		result_fire = arst_n && result_ch.valid && result_ch.ready;
		if (result_fire) begin
			if (expected_results.size() == 0) begin
				$error("result item arrived with no expectation pending");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				compare_field("handled", 8'(want.handled), 8'(result_ch.handled));
				compare_field("menu_visible", 8'(want.menu_visible),
					8'(result_ch.menu_visible));
				compare_field("selected_row", 8'(want.selected_row),
					8'(result_ch.selected_row));
				compare_field("selected_page", 8'(want.selected_page),
					8'(result_ch.selected_page));
				compare_field("selected_level", 8'(want.selected_level),
					8'(result_ch.selected_level));
			end
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_SETTING_COUNT: cfg_count = int'(cfg_ch.data);
				REG_GEOMETRY_START: cfg_geo = int'(cfg_ch.data);
				REG_TUBE_START: cfg_tube = int'(cfg_ch.data);
				default: ;
			endcase
		end
		if (item_fire)
			expected_results.push_back(predict_menu_result({item_ch.cmd, item_ch.shift_held,
				item_ch.write_index, item_ch.write_level}));
	end

	// Item driver: the gap before the next item is drawn when an item goes out.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_fire)) begin
			if (send_wait > 0) begin
				item_valid <= 1'b0;
				send_wait--;
			end else if (pending_events.size() != 0) begin
				next_event = pending_events.pop_front();
				item_valid <= 1'b1;
				item_cmd   <= next_event.cmd;
				item_shift <= next_event.shift;
				item_index <= next_event.index;
				item_level <= next_event.level;
				send_wait = quiet ? 0 : int'($urandom_range(0, 3));
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_fire)
				hold_off = quiet ? 0 : int'($urandom_range(0, 3));
			if (hold_off > 0) begin
				result_ready <= 1'b0;
				hold_off--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		do begin
			@(posedge clk);
			cycle_count++;
		end while (cycle_count < CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// The stimulus side tracks the shown flag so that most random keys land
	// while the menu is up.
	task automatic queue_key(logic [CMD_W-1:0] c, logic s, logic [ROW_W-1:0] idx,
			logic [LEVEL_W-1:0] lvl);
		if (c == CMD_TOGGLE)
			gen_shown = !gen_shown;
		else if (c == CMD_ESC)
			gen_shown = 1'b0;
		pending_events.push_back({c, s, idx, lvl});
	endtask

	task automatic queue_random_key();
		int               pick;
		logic [CMD_W-1:0] c;
		pick = $urandom_range(0, 99);
		if (!gen_shown) begin
			if (pick < 70)
				c = CMD_TOGGLE;
			else if (pick < 85)
				c = CMD_WRITE;
			else if (pick < 93)
				c = CMD_W'($urandom_range(CMD_ESC, CMD_END));
			else
				c = pick[0] ? CMD_OTHER : CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end else begin
			if (pick < 2)
				c = CMD_TOGGLE;
			else if (pick < 4)
				c = CMD_ESC;
			else if (pick < 16)
				c = CMD_WRITE;
			else if (pick < 20)
				c = pick[0] ? CMD_OTHER : CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			else
				c = CMD_W'($urandom_range(CMD_UP, CMD_END));
		end
		queue_key(c, 1'($urandom_range(0, 1)), ROW_W'($urandom_range(0, 31)),
			LEVEL_W'($urandom_range(0, 127)));
	endtask

	task automatic drain();
		while (pending_events.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready))
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] cnt, logic [CFG_W-1:0] geo,
			logic [CFG_W-1:0] tube, bit no_gaps);
		drain();
		write_reg(REG_SPARE, CFG_W'($urandom_range(0, 63)));
		write_reg(REG_SETTING_COUNT, cnt);
		write_reg(REG_GEOMETRY_START, geo);
		write_reg(REG_TUBE_START, tube);
		@(posedge clk);
		quiet = no_gaps;
		repeat (PHASE_ITEMS) queue_random_key();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 18 rows, pages start at 0, 6 and 12.
		queue_key(CMD_DOWN, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_RIGHT, 1'b1, 5'd0, 7'd0);
		queue_key(CMD_OTHER, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_SPARE_LO, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_SPARE_HI, 1'b1, 5'd31, 7'd127);
		queue_key(CMD_WRITE, 1'b0, 5'd31, 7'd127);
		queue_key(CMD_WRITE, 1'b1, 5'd0, 7'd127);
		queue_key(CMD_WRITE, 1'b0, 5'd17, 7'd0);
		queue_key(CMD_TOGGLE, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_LEFT, 1'b1, 5'd0, 7'd0);
		queue_key(CMD_RIGHT, 1'b1, 5'd0, 7'd0);
		queue_key(CMD_RIGHT, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_HOME, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_LEFT, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_RIGHT, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_UP, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_DOWN, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_TAB, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_TAB, 1'b1, 5'd0, 7'd0);
		queue_key(CMD_PGUP, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_PGDN, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_END, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_ESC, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_ESC, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_TOGGLE, 1'b0, 5'd0, 7'd0);
		queue_key(CMD_TOGGLE, 1'b0, 5'd0, 7'd0);

		// Extremes, an oversized and a zero count, and page starts out of order.
		run_phase(6'd1, 6'd0, 6'd0, 1'b0);
		run_phase(6'd32, 6'd32, 6'd32, 1'b1);
		run_phase(6'd0, 6'd63, 6'd63, 1'b0);
		run_phase(6'd40, 6'd20, 6'd10, 1'b0);
		run_phase(6'd10, 6'd8, 6'd3, 1'b1);
		run_phase(6'd5, 6'd0, 6'd5, 1'b0);
		run_phase(6'd32, 6'd11, 6'd22, 1'b0);
		repeat (3)
			run_phase(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)),
				CFG_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		drain();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
